// ===== hdl/cll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_pkg: shared types and constants for the cursor linked list engine
// Node pointers use CAPACITY as the null encoding.
// ----------------------------------------------------------------------------
package cll_pkg;
  localparam int CAPACITY  = 1024;
  localparam int DATA_BITS = 32;
  localparam int PTR_W     = $clog2(CAPACITY) + 1;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  localparam logic [3:0] OP_INSERT = 4'd0;
  localparam logic [3:0] OP_APPEND = 4'd1;
  localparam logic [3:0] OP_DELETE = 4'd2;
  localparam logic [3:0] OP_NEXT   = 4'd3;
  localparam logic [3:0] OP_PREV   = 4'd4;
  localparam logic [3:0] OP_START  = 4'd5;
  localparam logic [3:0] OP_END    = 4'd6;
  localparam logic [3:0] OP_SETPOS = 4'd7;
  localparam logic [3:0] OP_GET    = 4'd8;
  localparam logic [3:0] OP_SETVAL = 4'd9;
  localparam logic [3:0] OP_CLEAR  = 4'd10;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] item_value;
    logic [9:0]         position;
    logic               do_clear;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [10:0]        count;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_req;    // capture request, start node reads at cursor
    logic rd_walk;     // read link at walk pointer
    logic walk_step;   // advance walk pointer to read link
    logic commit;      // apply the operation's state update
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic walk_needed; // op requires a walk from head
    logic walk_done;   // walk target found or exhausted
  } sts_t;
endpackage

// ===== hdl/cll_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_ctrl: operation sequencer
// Steps each request through read, optional link walk, commit and respond.
// ----------------------------------------------------------------------------
module cll_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          out_busy,
  output logic          out_load,
  output cll_pkg::cmd_t cmd,
  input  cll_pkg::sts_t sts
);
  import cll_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_WCHK = 3'd3;
  localparam logic [2:0] S_COMM = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_load = 1'b0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load_req = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        // node read data at cursor now available
        state_next = sts.walk_needed ? S_WRD : S_COMM;
      end
      S_WRD: begin
        cmd.rd_walk = 1'b1;
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (sts.walk_done) state_next = S_COMM;
        else begin
          cmd.walk_step = 1'b1;
          state_next = S_WRD;
        end
      end
      S_COMM: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_req, cmd.rd_walk, cmd.walk_step, cmd.commit}))
    else $error("multiple commands");
  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> out_load) else $error("commit without result");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> state == S_READ) else $error("bad start");
endmodule

// ===== hdl/cll_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_datapath: node memories, free stack and list pointers
// Memories have registered reads; at most one node read per cycle.
// ----------------------------------------------------------------------------
module cll_datapath (
  input  logic          clk,
  input  logic          rst,
  input  cll_pkg::req_t req_in,
  input  cll_pkg::cmd_t cmd,
  output cll_pkg::sts_t sts,
  output cll_pkg::rsp_t rsp
);
  import cll_pkg::*;

  logic [DATA_BITS-1:0] node_data [CAPACITY];
  logic [PTR_W-1:0]     node_link [CAPACITY];
  logic [IDX_W-1:0]     free_slots [CAPACITY];

  logic [PTR_W-1:0] free_top, fresh_mark, head_ptr, tail_ptr, cursor_ptr, elem_count;
  req_t             req;
  logic [DATA_BITS-1:0] rd_data;
  logic [PTR_W-1:0]     rd_link, walk_ptr, prev_ptr;
  logic [IDX_W-1:0]     free_rd;
  logic [PTR_W-1:0]     steps;

  logic clr, cur_ok, head_ok, is_prev, is_pos, is_del;
  assign clr     = req.do_clear || (req.op == OP_CLEAR);
  assign cur_ok  = (cursor_ptr != NIL);
  assign head_ok = (head_ptr != NIL);
  assign is_prev = !clr && req.op == OP_PREV && cur_ok && cursor_ptr != head_ptr;
  assign is_del  = !clr && req.op == OP_DELETE && cur_ok && cursor_ptr != head_ptr;
  assign is_pos  = !clr && req.op == OP_SETPOS
                   && {1'b0, req.position} < elem_count;
  assign sts.walk_needed = is_prev || is_del || is_pos;

  // walk: rd_link is link of walk_ptr; stop at predecessor or at position
  assign sts.walk_done = is_pos ? (steps[9:0] == req.position)
                                : ((rd_link == cursor_ptr) || (steps == NIL));

  // allocation
  logic [PTR_W-1:0] new_slot;
  logic             can_add;
  always_comb begin
    if (free_top != '0) new_slot = {1'b0, free_rd};
    else new_slot = fresh_mark;
    can_add = (elem_count < NIL) && (new_slot != NIL);
  end

  // node memory read address
  logic [IDX_W-1:0] rd_addr;
  always_comb begin
    if (cmd.load_req) rd_addr = req_in.position[IDX_W-1:0] ^ req_in.position[IDX_W-1:0]
                                ^ cursor_ptr[IDX_W-1:0];
    else rd_addr = walk_ptr[IDX_W-1:0];
  end

  // commit writes
  logic             lw_en, dw_en, fw_en;
  logic [IDX_W-1:0] lw_a, dw_a;
  logic [PTR_W-1:0] lw_d;
  logic [DATA_BITS-1:0] dw_d;
  logic             lw2_en;
  logic [IDX_W-1:0] lw2_a;
  logic [PTR_W-1:0] lw2_d;
  logic [PTR_W-1:0] n_head, n_tail, n_cur, n_cnt, n_ftop, n_fresh;
  logic             ok;
  logic [DATA_BITS-1:0] rv;

  always_comb begin
    lw_en = 1'b0; lw_a = new_slot[IDX_W-1:0]; lw_d = NIL;
    lw2_en = 1'b0; lw2_a = cursor_ptr[IDX_W-1:0]; lw2_d = new_slot;
    dw_en = 1'b0; dw_a = new_slot[IDX_W-1:0]; dw_d = req.item_value[DATA_BITS-1:0];
    fw_en = 1'b0;
    n_head = head_ptr; n_tail = tail_ptr; n_cur = cursor_ptr; n_cnt = elem_count;
    n_ftop = free_top; n_fresh = fresh_mark;
    ok = 1'b0; rv = '0;
    if (clr) begin
      ok = 1'b1; n_head = NIL; n_tail = NIL; n_cur = NIL; n_cnt = '0;
      n_ftop = '0; n_fresh = '0;
    end else begin
      case (req.op)
        OP_INSERT, OP_APPEND: if (can_add) begin
          ok = 1'b1; dw_en = 1'b1; lw_en = 1'b1; n_cnt = elem_count + 1'b1;
          if (free_top != '0) n_ftop = free_top - 1'b1;
          else n_fresh = fresh_mark + 1'b1;
          if (!head_ok) begin
            n_head = new_slot; n_tail = new_slot; n_cur = new_slot;
          end else if (req.op == OP_INSERT && cur_ok) begin
            lw_d = rd_link; lw2_en = 1'b1;
            if (tail_ptr == cursor_ptr) n_tail = new_slot;
          end else begin
            lw2_en = (tail_ptr != NIL); lw2_a = tail_ptr[IDX_W-1:0];
            n_tail = new_slot;
          end
        end
        OP_DELETE: if (cur_ok) begin
          if (cursor_ptr == head_ptr) begin
            ok = 1'b1; n_head = rd_link;
            if (rd_link != NIL) n_cur = rd_link;
            else begin n_cur = NIL; n_tail = NIL; end
          end else if (walk_ptr != NIL && rd_link == cursor_ptr) begin
            ok = 1'b1; lw2_en = 1'b1; lw2_a = walk_ptr[IDX_W-1:0]; lw2_d = prev_ptr;
            if (prev_ptr != NIL) n_cur = prev_ptr;
            else begin n_cur = walk_ptr; n_tail = walk_ptr; end
          end
          if (ok) begin
            rv = rd_data;
            if (free_top < NIL) begin fw_en = 1'b1; n_ftop = free_top + 1'b1; end
            if (elem_count != '0) n_cnt = elem_count - 1'b1;
          end
        end
        OP_NEXT: if (cur_ok && cursor_ptr != tail_ptr) begin
          ok = 1'b1; n_cur = rd_link;
        end
        OP_PREV: if (is_prev && walk_ptr != NIL && rd_link == cursor_ptr) begin
          ok = 1'b1; n_cur = walk_ptr;
        end
        OP_START: if (head_ok) begin ok = 1'b1; n_cur = head_ptr; end
        OP_END: if (elem_count != '0 && tail_ptr != NIL) begin
          ok = 1'b1; n_cur = tail_ptr;
        end
        OP_SETPOS: if (is_pos && walk_ptr != NIL) begin ok = 1'b1; n_cur = walk_ptr; end
        OP_GET: if (cur_ok) begin ok = 1'b1; rv = rd_data; end
        OP_SETVAL: if (head_ok && cur_ok) begin
          ok = 1'b1; dw_en = 1'b1; dw_a = cursor_ptr[IDX_W-1:0];
        end
        default: ok = 1'b0;
      endcase
    end
  end

  // memories; node data is read only at the cursor, links also during walks
  always_ff @(posedge clk) begin
    if (cmd.load_req) rd_data <= node_data[rd_addr];
    if (cmd.load_req || cmd.rd_walk) rd_link <= node_link[rd_addr];
    if (cmd.commit && dw_en) node_data[dw_a] <= dw_d;
    if (cmd.commit && lw_en) node_link[lw_a] <= lw_d;
    if (cmd.commit && lw2_en) node_link[lw2_a] <= lw2_d;
  end

  always_ff @(posedge clk) begin
    free_rd <= free_slots[free_top[IDX_W-1:0] - 1'b1];
    if (cmd.commit && fw_en) free_slots[free_top[IDX_W-1:0]] <= cursor_ptr[IDX_W-1:0];
  end

  // request, walk and pointer registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= req_in;
      walk_ptr <= head_ptr;
      steps <= '0;
    end
    // first walk read still sees the cursor's link; keep it for the delete relink
    if (cmd.rd_walk && steps == '0) prev_ptr <= rd_link;
    if (cmd.walk_step) begin
      walk_ptr <= rd_link;
      steps <= steps + 1'b1;
    end
  end

  // response from the commit decode
  always_comb begin
    rsp.ok = ok;
    rsp.read_value = 32'(signed'(rv));
    rsp.count = n_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= '0; fresh_mark <= '0; head_ptr <= NIL; tail_ptr <= NIL;
      cursor_ptr <= NIL; elem_count <= '0;
    end else if (cmd.commit) begin
      free_top <= n_ftop; fresh_mark <= n_fresh; head_ptr <= n_head;
      tail_ptr <= n_tail; cursor_ptr <= n_cur; elem_count <= n_cnt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    elem_count <= NIL) else $error("count overflow");
  a_empty_nil: assert property (@(posedge clk) disable iff (rst)
    (elem_count == '0) |-> (head_ptr == NIL || $past(cmd.commit) == 1'b0))
    else $error("empty list with head");
  a_head_cur: assert property (@(posedge clk) disable iff (rst)
    (head_ptr == NIL) |-> (cursor_ptr == NIL)) else $error("cursor without head");
endmodule

// ===== hdl/cursor_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_list_engine: bounded singly linked list with a cursor
// Top level joining the sequencer, the node datapath and the result register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall carrying req (op, item_value,
//   position, do_clear). One response per request leaves on out_valid /
//   out_stall carrying rsp (ok, read_value, count).
//   One request is handled at a time. Simple operations go from transfer
//   to result through one node memory read, then commit. Prev, setpos and
//   delete of a non-head node walk links from head, one link read and one
//   check per node visited; the walk is bound by the single registered
//   read port of the link memory.
//   The result sits in an output register; the next request can be taken
//   while it waits, but its commit holds until the register is free.
//   Reset clears the list pointers and counters; node memories need no
//   clearing since every slot is written before its contents are used.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cll_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cll_pkg::rsp_t out_data
);
  import cll_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  logic out_load;

  cll_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_valid && out_stall), .out_load(out_load), .cmd(cmd), .sts(sts)
  );

  cll_datapath u_dp (
    .clk(clk), .rst(rst), .req_in(in_data), .cmd(cmd), .sts(sts), .rsp(rsp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) out_data <= rsp;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall)) else $error("result overwritten");
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.count <= 11'(CAPACITY)) else $error("count range");
endmodule
